// ===== design/lcdns_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types and constants of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam int LINE_LENGTH_DEF = 40;
  localparam int TICK_WIDTH_DEF  = 23;

  localparam int HOLD_W  = 24;
  localparam int UPC_W   = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [HOLD_W-1:0] HOLD_MAX = 24'hFFFFFF;

  localparam int DATA_PULSE_RST = 10;
  localparam int LONG_WAIT_RST  = 50000;
  localparam int CMD2_PULSE_RST = 100;
  localparam int POS_WAIT_RST   = 100;
  localparam int CLEAR_WAIT_RST = 1000;
  localparam int POWER_UP_RST   = 5000000;

  localparam logic [UPC_W-1:0] UPC_INIT = 5'd0;
  localparam logic [UPC_W-1:0] UPC_BYTE = 5'd23;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [6:0] LINE2_OFFSET  = 7'h40;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_CMD   = 3'd1,
    OP_DATA  = 3'd2,
    OP_POS   = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_PULSE = 3'd0,
    REG_LONG_WAIT  = 3'd1,
    REG_CMD2_PULSE = 3'd2,
    REG_POS_WAIT   = 3'd3,
    REG_CLEAR_WAIT = 3'd4,
    REG_POWER_UP   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    NS_CONST = 2'd0,
    NS_HI    = 2'd1,
    NS_LO    = 2'd2
  } nib_sel_t;

  typedef enum logic [2:0] {
    HS_ZERO       = 3'd0,
    HS_POWER      = 3'd1,
    HS_LONG       = 3'd2,
    HS_CMD2       = 3'd3,
    HS_FIRST      = 3'd4,
    HS_SECOND     = 3'd5,
    HS_LONG_EXTRA = 3'd6
  } hold_sel_t;

  typedef enum logic [1:0] {
    EX_NONE  = 2'd0,
    EX_POS   = 2'd1,
    EX_CLEAR = 2'd2
  } extra_sel_t;

  typedef struct packed {
    nib_sel_t   nib_sel;
    logic [3:0] nib;
    logic       rs_req;
    logic       en;
    hold_sel_t  hold_sel;
    logic       last;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       data_mode;
    extra_sel_t extra;
  } req_t;

endpackage

// ===== design/lcdns_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// lcdns_ucode_rom
// Microprogram store: one control word per sequencer step.
// ----------------------------------------------------------------------------
module lcdns_ucode_rom
  import lcdns_pkg::*;
(
  input  logic [UPC_W-1:0] upc,
  output ctrl_t            ctrl
);

  function automatic ctrl_t uw(nib_sel_t ns, logic [3:0] nib, logic rs, logic en,
                               hold_sel_t hs, logic last);
    ctrl_t w;
    w.nib_sel  = ns;
    w.nib      = nib;
    w.rs_req   = rs;
    w.en       = en;
    w.hold_sel = hs;
    w.last     = last;
    return w;
  endfunction

  always_comb begin
    case (upc)
      // power-up sequence
      5'd0:  ctrl = uw(NS_CONST, 4'h0, 1'b0, 1'b0, HS_POWER,      1'b0);
      5'd1:  ctrl = uw(NS_CONST, 4'h0, 1'b0, 1'b0, HS_POWER,      1'b0);
      5'd2:  ctrl = uw(NS_CONST, 4'h3, 1'b0, 1'b1, HS_LONG,       1'b0);
      5'd3:  ctrl = uw(NS_CONST, 4'h3, 1'b0, 1'b0, HS_LONG,       1'b0);
      5'd4:  ctrl = uw(NS_CONST, 4'h3, 1'b0, 1'b1, HS_LONG,       1'b0);
      5'd5:  ctrl = uw(NS_CONST, 4'h3, 1'b0, 1'b0, HS_LONG,       1'b0);
      5'd6:  ctrl = uw(NS_CONST, 4'h3, 1'b0, 1'b1, HS_LONG,       1'b0);
      5'd7:  ctrl = uw(NS_CONST, 4'h3, 1'b0, 1'b0, HS_LONG,       1'b0);
      5'd8:  ctrl = uw(NS_CONST, 4'h2, 1'b0, 1'b1, HS_LONG,       1'b0);
      5'd9:  ctrl = uw(NS_CONST, 4'h2, 1'b0, 1'b0, HS_ZERO,       1'b0);
      // function set 0x28
      5'd10: ctrl = uw(NS_CONST, 4'h2, 1'b0, 1'b1, HS_LONG,       1'b0);
      5'd11: ctrl = uw(NS_CONST, 4'h2, 1'b0, 1'b0, HS_LONG,       1'b0);
      5'd12: ctrl = uw(NS_CONST, 4'h8, 1'b0, 1'b1, HS_CMD2,       1'b0);
      5'd13: ctrl = uw(NS_CONST, 4'h8, 1'b0, 1'b0, HS_LONG,       1'b0);
      // entry mode 0x06
      5'd14: ctrl = uw(NS_CONST, 4'h0, 1'b0, 1'b1, HS_LONG,       1'b0);
      5'd15: ctrl = uw(NS_CONST, 4'h0, 1'b0, 1'b0, HS_LONG,       1'b0);
      5'd16: ctrl = uw(NS_CONST, 4'h6, 1'b0, 1'b1, HS_CMD2,       1'b0);
      5'd17: ctrl = uw(NS_CONST, 4'h6, 1'b0, 1'b0, HS_LONG,       1'b0);
      // display on 0x0C
      5'd18: ctrl = uw(NS_CONST, 4'h0, 1'b0, 1'b1, HS_LONG,       1'b0);
      5'd19: ctrl = uw(NS_CONST, 4'h0, 1'b0, 1'b0, HS_LONG,       1'b0);
      5'd20: ctrl = uw(NS_CONST, 4'hC, 1'b0, 1'b1, HS_CMD2,       1'b0);
      5'd21: ctrl = uw(NS_CONST, 4'hC, 1'b0, 1'b0, HS_LONG,       1'b0);
      5'd22: ctrl = uw(NS_CONST, 4'hC, 1'b0, 1'b0, HS_LONG,       1'b1);
      // generic byte transfer
      5'd23: ctrl = uw(NS_HI,    4'h0, 1'b1, 1'b1, HS_FIRST,      1'b0);
      5'd24: ctrl = uw(NS_HI,    4'h0, 1'b1, 1'b0, HS_LONG,       1'b0);
      5'd25: ctrl = uw(NS_LO,    4'h0, 1'b1, 1'b1, HS_SECOND,     1'b0);
      5'd26: ctrl = uw(NS_LO,    4'h0, 1'b1, 1'b0, HS_LONG_EXTRA, 1'b1);
      default: ctrl = uw(NS_CONST, 4'h0, 1'b0, 1'b0, HS_ZERO,     1'b1);
    endcase
  end

endmodule

// ===== design/lcdns_datapath.sv =====
// ----------------------------------------------------------------------------
// lcdns_datapath
// Timing registers and pin event formation from the current control word.
// ----------------------------------------------------------------------------
module lcdns_datapath
  import lcdns_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TICK_WIDTH-1:0] cfg_wdata,
  input  ctrl_t                 ctrl,
  input  req_t                  req,
  output logic [3:0]            ev_nibble,
  output logic                  ev_rs,
  output logic [HOLD_W-1:0]     ev_hold
);

  localparam int SUM_W = (TICK_WIDTH + 1 > HOLD_W) ? TICK_WIDTH + 1 : HOLD_W;

  logic [TICK_WIDTH-1:0] data_pulse_r;
  logic [TICK_WIDTH-1:0] long_wait_r;
  logic [TICK_WIDTH-1:0] cmd2_pulse_r;
  logic [TICK_WIDTH-1:0] pos_wait_r;
  logic [TICK_WIDTH-1:0] clear_wait_r;
  logic [TICK_WIDTH-1:0] power_up_r;

  logic [TICK_WIDTH-1:0] base;
  logic [TICK_WIDTH-1:0] extra;
  logic [SUM_W-1:0]      sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_pulse_r <= TICK_WIDTH'(DATA_PULSE_RST);
      long_wait_r  <= TICK_WIDTH'(LONG_WAIT_RST);
      cmd2_pulse_r <= TICK_WIDTH'(CMD2_PULSE_RST);
      pos_wait_r   <= TICK_WIDTH'(POS_WAIT_RST);
      clear_wait_r <= TICK_WIDTH'(CLEAR_WAIT_RST);
      power_up_r   <= TICK_WIDTH'(POWER_UP_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DATA_PULSE: data_pulse_r <= cfg_wdata;
        REG_LONG_WAIT:  long_wait_r  <= cfg_wdata;
        REG_CMD2_PULSE: cmd2_pulse_r <= cfg_wdata;
        REG_POS_WAIT:   pos_wait_r   <= cfg_wdata;
        REG_CLEAR_WAIT: clear_wait_r <= cfg_wdata;
        REG_POWER_UP:   power_up_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl.nib_sel)
      NS_HI:   ev_nibble = req.byte_val[7:4];
      NS_LO:   ev_nibble = req.byte_val[3:0];
      default: ev_nibble = ctrl.nib;
    endcase
    ev_rs = ctrl.rs_req & req.data_mode;

    extra = '0;
    case (ctrl.hold_sel)
      HS_POWER:  base = power_up_r;
      HS_LONG:   base = long_wait_r;
      HS_CMD2:   base = cmd2_pulse_r;
      HS_FIRST:  base = req.data_mode ? data_pulse_r : long_wait_r;
      HS_SECOND: base = req.data_mode ? data_pulse_r : cmd2_pulse_r;
      HS_LONG_EXTRA: begin
        base = long_wait_r;
        case (req.extra)
          EX_POS:   extra = pos_wait_r;
          EX_CLEAR: extra = clear_wait_r;
          default:  extra = '0;
        endcase
      end
      default:   base = '0;
    endcase

    sum     = SUM_W'(base) + SUM_W'(extra);
    ev_hold = (sum > SUM_W'(HOLD_MAX)) ? HOLD_MAX : sum[HOLD_W-1:0];
  end

endmodule

// ===== design/char_lcd_nibble_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Character LCD 4-bit bus sequencer: expands requests into pin events.
// ----------------------------------------------------------------------------
// Each accepted request (init, command, data character, cursor position,
// clear) runs a microprogram that emits one pin event per cycle while the
// output side takes them: 23 events for init, 4 for the others, unknown ops
// produce none. A request occupies the block from its accept, stepped by the
// microprogram step counter, until its last event is in the output register;
// output stalls stretch that, and the next request is taken as soon as the
// last event is registered. Timing registers are written through the cfg
// port; the user must write them only while idle, not enforced by the block.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core
  import lcdns_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF,
  parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TICK_WIDTH-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_op,
  input  logic [7:0]            in_byte_value,
  input  logic [1:0]            in_line_select,
  input  logic [5:0]            in_column,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_data_nibble,
  output logic                  out_reg_select,
  output logic                  out_enable_line,
  output logic                  out_read_write,
  output logic [HOLD_W-1:0]     out_hold_ticks,
  output logic                  out_last_event
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t           state_r;
  logic [UPC_W-1:0] upc_r;
  req_t             req_r;
  req_t             req_nxt;
  logic             op_known;
  logic [UPC_W-1:0] entry;

  logic             out_valid_r;
  logic [3:0]       out_nibble_r;
  logic             out_rs_r;
  logic             out_en_r;
  logic [HOLD_W-1:0] out_hold_r;
  logic             out_last_r;

  ctrl_t            ctrl;
  logic [3:0]       ev_nibble;
  logic             ev_rs;
  logic [HOLD_W-1:0] ev_hold;

  logic [5:0]       col_c;
  logic [6:0]       ddram_addr;
  logic             slot_free;

  lcdns_ucode_rom u_rom (
    .upc  (upc_r),
    .ctrl (ctrl)
  );

  lcdns_datapath #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .req       (req_r),
    .ev_nibble (ev_nibble),
    .ev_rs     (ev_rs),
    .ev_hold   (ev_hold)
  );

  always_comb begin
    if (in_column == 6'd0) begin
      col_c = 6'd1;
    end else if (in_column > 6'(LINE_LENGTH)) begin
      col_c = 6'(LINE_LENGTH);
    end else begin
      col_c = in_column;
    end
    ddram_addr = ((in_line_select == 2'd1) ? 7'h00 : LINE2_OFFSET) + {1'b0, col_c} - 7'd1;

    req_nxt.byte_val  = in_byte_value;
    req_nxt.data_mode = 1'b0;
    req_nxt.extra     = EX_NONE;
    op_known          = 1'b1;
    entry             = UPC_BYTE;
    case (in_op)
      OP_INIT:  entry = UPC_INIT;
      OP_CMD:   ;
      OP_DATA:  req_nxt.data_mode = 1'b1;
      OP_POS: begin
        req_nxt.byte_val = CMD_SET_DDRAM | {1'b0, ddram_addr};
        req_nxt.extra    = EX_POS;
      end
      OP_CLEAR: begin
        req_nxt.byte_val = CMD_CLEAR;
        req_nxt.extra    = EX_CLEAR;
      end
      default:  op_known = 1'b0;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upc_r       <= UPC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_valid && op_known) begin
            req_r   <= req_nxt;
            upc_r   <= entry;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_nibble_r <= ev_nibble;
            out_rs_r     <= ev_rs;
            out_en_r     <= ctrl.en;
            out_hold_r   <= ev_hold;
            out_last_r   <= ctrl.last;
            upc_r        <= upc_r + 5'd1;
            if (ctrl.last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_nibble = out_nibble_r;
  assign out_reg_select  = out_rs_r;
  assign out_enable_line = out_en_r;
  assign out_read_write  = 1'b0;
  assign out_hold_ticks  = out_hold_r;
  assign out_last_event  = out_last_r;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the character LCD nibble sequencer core.
// ----------------------------------------------------------------------------
// Requests for every operation are sent through the valid/ready input, with
// bursts and gaps on the sender side and random stalls on the output side.
// A local model of the sequencer expands each accepted request into its run
// of pin events. A checker compares every event leaving the block, field by
// field, with the oldest expected event. The timing registers are reloaded
// between phases: reset values, all zero, all ones and random mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import lcdns_pkg::*;

  localparam int LINE_LEN        = LINE_LENGTH_DEF;
  localparam int NUM_TIMING      = 6;
  localparam int MAX_RUN         = 23;
  localparam int SETTLE_CYCLES   = 30;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_PHASES   = 5;
  localparam int PHASE_REQUESTS  = 64;

  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] BUS4_NIBBLE   = 4'h2;
  localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [7:0] DISPLAY_ON    = 8'h0C;
  localparam logic [1:0] LINE_FIRST    = 2'd1;
  localparam logic [1:0] LINE_SECOND   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef logic [TICK_WIDTH_DEF-1:0] tick_t;

  typedef enum int {
    TIMING_RESET,
    TIMING_ZERO,
    TIMING_MAX,
    TIMING_RANDOM
  } timing_kind_t;

  typedef struct packed {
    logic [3:0]        nibble;
    logic              rs;
    logic              en;
    logic              rw;
    logic [HOLD_W-1:0] hold;
    logic              is_last;
  } pin_event_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [TICK_WIDTH_DEF-1:0] cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [2:0]                in_op = '0;
  logic [7:0]                in_byte_value = '0;
  logic [1:0]                in_line_select = '0;
  logic [5:0]                in_column = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [3:0]                out_data_nibble;
  logic                      out_reg_select;
  logic                      out_enable_line;
  logic                      out_read_write;
  logic [HOLD_W-1:0]         out_hold_ticks;
  logic                      out_last_event;

  char_lcd_nibble_sequencer_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_byte_value   (in_byte_value),
    .in_line_select  (in_line_select),
    .in_column       (in_column),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_nibble (out_data_nibble),
    .out_reg_select  (out_reg_select),
    .out_enable_line (out_enable_line),
    .out_read_write  (out_read_write),
    .out_hold_ticks  (out_hold_ticks),
    .out_last_event  (out_last_event)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow timing registers and the pin events still owed by the block
  tick_t      timing [NUM_TIMING];
  pin_event_t run_buf [MAX_RUN];
  int         run_len;
  pin_event_t expected_events [$];
  int         failures = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;

  // --------------------------------------------------------------------------
  // sequencer model
  // --------------------------------------------------------------------------
  function automatic void add_event(logic [3:0] nib, logic rs, logic en,
                                    logic [HOLD_W:0] hold);
    pin_event_t ev;
    ev.nibble  = nib;
    ev.rs      = rs;
    ev.en      = en;
    ev.rw      = 1'b0;
    ev.hold    = (hold > {1'b0, HOLD_MAX}) ? HOLD_MAX : hold[HOLD_W-1:0];
    ev.is_last = 1'b0;
    run_buf[run_len] = ev;
    run_len++;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic rs, tick_t first,
                                   tick_t second, tick_t extra);
    logic [HOLD_W:0] settle;
    settle = {2'b00, timing[REG_LONG_WAIT]} + {2'b00, extra};
    add_event(b[7:4], rs, 1'b1, {2'b00, first});
    add_event(b[7:4], rs, 1'b0, {2'b00, timing[REG_LONG_WAIT]});
    add_event(b[3:0], rs, 1'b1, {2'b00, second});
    add_event(b[3:0], rs, 1'b0, settle);
  endfunction

  function automatic void add_command(logic [7:0] b, tick_t extra);
    add_byte(b, 1'b0, timing[REG_LONG_WAIT], timing[REG_CMD2_PULSE], extra);
  endfunction

  function automatic void predict_pin_events(logic [2:0] op, logic [7:0] b,
                                             logic [1:0] line, logic [5:0] col);
    logic [5:0] c;
    logic [7:0] addr;
    run_len = 0;
    case (op)
      OP_INIT: begin
        add_event(4'h0, 1'b0, 1'b0, {2'b00, timing[REG_POWER_UP]});
        add_event(4'h0, 1'b0, 1'b0, {2'b00, timing[REG_POWER_UP]});
        repeat (3) begin
          add_event(WAKE_NIBBLE, 1'b0, 1'b1, {2'b00, timing[REG_LONG_WAIT]});
          add_event(WAKE_NIBBLE, 1'b0, 1'b0, {2'b00, timing[REG_LONG_WAIT]});
        end
        add_event(BUS4_NIBBLE, 1'b0, 1'b1, {2'b00, timing[REG_LONG_WAIT]});
        add_event(BUS4_NIBBLE, 1'b0, 1'b0, '0);
        add_command(FUNC_SET_4BIT, '0);
        add_command(ENTRY_MODE, '0);
        add_command(DISPLAY_ON, '0);
        add_event(DISPLAY_ON[3:0], 1'b0, 1'b0, {2'b00, timing[REG_LONG_WAIT]});
      end
      OP_CMD:  add_command(b, '0);
      OP_DATA: add_byte(b, 1'b1, timing[REG_DATA_PULSE], timing[REG_DATA_PULSE], '0);
      OP_POS: begin
        c = col;
        if (c < 6'd1) c = 6'd1;
        if (c > 6'(LINE_LEN)) c = 6'(LINE_LEN);
        addr = ((line == LINE_FIRST) ? 8'h00 : {1'b0, LINE2_OFFSET}) + {2'b00, c} - 8'd1;
        add_command(CMD_SET_DDRAM | {1'b0, addr[6:0]}, timing[REG_POS_WAIT]);
      end
      OP_CLEAR: add_command(CMD_CLEAR, timing[REG_CLEAR_WAIT]);
      default: ;
    endcase
    if (run_len > 0) run_buf[run_len-1].is_last = 1'b1;
    for (int i = 0; i < run_len; i++) expected_events.push_back(run_buf[i]);
  endfunction

  // --------------------------------------------------------------------------
  // request sender, bursts with random gaps
  // --------------------------------------------------------------------------
  task automatic send_request(logic [2:0] op, logic [7:0] b, logic [1:0] line,
                              logic [5:0] col);
    int  gap;
    bit  taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_op          <= op;
    in_byte_value  <= b;
    in_line_select <= line;
    in_column      <= col;
    in_valid       <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_ready;
      if (taken) predict_pin_events(op, b, line, col);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_random_request(output bit counted);
    logic [2:0] op;
    logic [1:0] line;
    logic [5:0] col;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) op = OP_INIT;
    else if (pick < 10) op = 3'($urandom_range(OP_CLEAR + 1, 7));
    else op = 3'($urandom_range(OP_CMD, OP_CLEAR));
    line = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                       : 2'($urandom_range(LINE_FIRST, LINE_SECOND));
    col  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(1, LINE_LEN));
    send_request(op, 8'($urandom_range(0, 255)), line, col);
    counted = (op <= OP_CLEAR);
  endtask

  // idle the input side and let every owed event come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic load_timing(timing_kind_t kind);
    tick_t v;
    for (int i = 0; i < NUM_TIMING; i++) begin
      case (kind)
        TIMING_ZERO: v = '0;
        TIMING_MAX:  v = '1;
        TIMING_RANDOM: begin
          case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = '1;
            2:       v = tick_t'($urandom_range(0, 2000));
            default: v = tick_t'($urandom);
          endcase
        end
        default: begin
          case (cfg_reg_t'(i))
            REG_DATA_PULSE: v = tick_t'(DATA_PULSE_RST);
            REG_LONG_WAIT:  v = tick_t'(LONG_WAIT_RST);
            REG_CMD2_PULSE: v = tick_t'(CMD2_PULSE_RST);
            REG_POS_WAIT:   v = tick_t'(POS_WAIT_RST);
            REG_CLEAR_WAIT: v = tick_t'(CLEAR_WAIT_RST);
            default:        v = tick_t'(POWER_UP_RST);
          endcase
        end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= v;
      timing[i] = v;
      @(posedge clk);
    end
    // writes past the last register must be ignored
    for (int i = IDX_UNUSED_LO; i <= IDX_UNUSED_HI; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= tick_t'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // output side: stall pattern in windows, some windows never stall
  // --------------------------------------------------------------------------
  int rx_window = 0;
  bit rx_stalls_on = 1'b0;
  int rx_stall_left = 0;

  always @(posedge clk) begin
    if (rx_window == 0) begin
      rx_window    <= $urandom_range(16, 200);
      rx_stalls_on <= ($urandom_range(0, 2) != 0);
    end else begin
      rx_window <= rx_window - 1;
    end
    if (rx_stall_left > 0) begin
      out_ready     <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
      out_ready     <= 1'b0;
      rx_stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // event checker and watchdog, sampled mid-cycle
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [HOLD_W-1:0] want,
                                        logic [HOLD_W-1:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 40)
        $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    pin_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        failures++;
        if (failures <= 40)
          $display("%0t  unexpected pin event: expected none, actual nibble %0h hold %0h",
                   $time, out_data_nibble, out_hold_ticks);
      end else begin
        want = expected_events.pop_front();
        compare_field("data_nibble", HOLD_W'(want.nibble), HOLD_W'(out_data_nibble));
        compare_field("reg_select", HOLD_W'(want.rs), HOLD_W'(out_reg_select));
        compare_field("enable_line", HOLD_W'(want.en), HOLD_W'(out_enable_line));
        compare_field("read_write", HOLD_W'(want.rw), HOLD_W'(out_read_write));
        compare_field("hold_ticks", want.hold, out_hold_ticks);
        compare_field("last_event", HOLD_W'(want.is_last), HOLD_W'(out_last_event));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("%0t  watchdog: no request moved for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("FAIL char_lcd_nibble_sequencer_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_reset_timing();
    send_request(OP_INIT, 8'h00, LINE_FIRST, 6'd1);
    send_request(OP_CMD, 8'h00, LINE_FIRST, 6'd1);
    send_request(OP_CMD, 8'hFF, LINE_SECOND, 6'd40);
    send_request(OP_DATA, 8'h00, LINE_FIRST, 6'd0);
    send_request(OP_DATA, 8'hFF, 2'd3, 6'd63);
    send_request(OP_DATA, 8'hA5, LINE_FIRST, 6'd1);
    send_request(OP_POS, 8'h00, LINE_FIRST, 6'd1);
    send_request(OP_POS, 8'hFF, LINE_SECOND, 6'd40);
    send_request(OP_POS, 8'h00, LINE_FIRST, 6'd0);    // column zero acts as one
    send_request(OP_POS, 8'h00, LINE_SECOND, 6'd63);  // past line end clamps
    send_request(OP_POS, 8'h00, 2'd0, 6'd17);         // other lines map to second
    send_request(OP_POS, 8'h00, 2'd3, 6'd41);
    send_request(OP_CLEAR, 8'h00, LINE_FIRST, 6'd1);
    for (int u = OP_CLEAR + 1; u < 8; u++)             // unknown ops give nothing
      send_request(3'(u), 8'h3C, LINE_FIRST, 6'd1);
    send_request(OP_CMD, 8'h5A, LINE_FIRST, 6'd1);
    wait_drained();
  endtask

  task automatic test_timing_extremes();
    for (int k = 0; k < 2; k++) begin
      load_timing(k == 0 ? TIMING_ZERO : TIMING_MAX);
      send_request(OP_INIT, 8'($urandom_range(0, 255)), LINE_FIRST, 6'd1);
      send_request(OP_CMD, 8'($urandom_range(0, 255)), LINE_FIRST, 6'd1);
      send_request(OP_DATA, 8'($urandom_range(0, 255)), LINE_FIRST, 6'd1);
      send_request(OP_POS, 8'h00, LINE_SECOND, 6'($urandom_range(0, 63)));
      send_request(OP_CLEAR, 8'h00, LINE_FIRST, 6'd1);
      wait_drained();
    end
  endtask

  task automatic test_random_requests();
    int  sent;
    bit  counted;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_timing(p == RANDOM_PHASES - 1 ? TIMING_RESET : TIMING_RANDOM);
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        send_random_request(counted);
        if (counted) sent++;
      end
      wait_drained();
    end
  endtask

  initial begin
    timing[REG_DATA_PULSE] = tick_t'(DATA_PULSE_RST);
    timing[REG_LONG_WAIT]  = tick_t'(LONG_WAIT_RST);
    timing[REG_CMD2_PULSE] = tick_t'(CMD2_PULSE_RST);
    timing[REG_POS_WAIT]   = tick_t'(POS_WAIT_RST);
    timing[REG_CLEAR_WAIT] = tick_t'(CLEAR_WAIT_RST);
    timing[REG_POWER_UP]   = tick_t'(POWER_UP_RST);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_reset_timing();
    test_timing_extremes();
    test_random_requests();

    if (expected_events.size() != 0) begin
      failures++;
      $display("%0t  missing pin events: expected %0d more, actual 0",
               $time, expected_events.size());
    end
    if (failures == 0) $display("PASS char_lcd_nibble_sequencer_core");
    else $display("FAIL char_lcd_nibble_sequencer_core");
    $finish;
  end

endmodule
